// ===== hw/rtl/lm_pkg.sv =====
// ----------------------------------------------------------------------------
// lm_pkg: shared types and constants for the list median core
// Holds the cell control word and the request and result field widths.
// ----------------------------------------------------------------------------
package lm_pkg;

   localparam int MEDIAN_BITS = 33;
   localparam int COUNT_BITS  = 8;
   localparam int REQ_BITS    = 32;

   // One command word, broadcast to every cell of the chain
   typedef struct packed {
      logic insert;  // place the broadcast value in ascending order
      logic shift;   // move every entry one cell toward the head
      logic clear;   // drop all entries
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/lm_cell.sv =====
// ----------------------------------------------------------------------------
// lm_cell: one cell of the sorting chain
// Holds one element and a valid bit. On insert it keeps its element, takes
// its left neighbor's or takes the new value; on shift it takes the right.
// ----------------------------------------------------------------------------
module lm_cell #(
   parameter int VALUE_BITS = 32,
   parameter bit FIRST      = 1'b0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lm_pkg::cell_ctrl_type         ctrl,
   input  logic signed [VALUE_BITS-1:0]  new_value,
   input  logic                          left_valid,
   input  logic signed [VALUE_BITS-1:0]  left_value,
   input  logic                          right_valid,
   input  logic signed [VALUE_BITS-1:0]  right_value,
   output logic                          cell_valid,
   output logic signed [VALUE_BITS-1:0]  cell_value
);
   import lm_pkg::*;

   logic                         valid_ff;
   logic                         valid_in;
   logic signed [VALUE_BITS-1:0] value_ff;
   logic signed [VALUE_BITS-1:0] value_in;
   logic                         keep;
   logic                         left_ok;
   logic                         left_gt;

   // An empty cell acts as plus infinity; the head has an open slot on its left
   assign keep    = valid_ff && (value_ff <= new_value);
   assign left_ok = FIRST ? 1'b1 : left_valid;
   assign left_gt = !FIRST && left_valid && (left_value > new_value);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         valid_in = right_valid;
         value_in = right_value;
      end else if (ctrl.insert) begin
         if (!keep && left_ok) begin
            valid_in = 1'b1;
            value_in = left_gt ? left_value : new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_valid = valid_ff;
   assign cell_value = value_ff;

endmodule

// ===== hw/rtl/list_median_core.sv =====
// ----------------------------------------------------------------------------
// list_median_core: median of a list of signed integers
// Sorts elements on arrival in a chain of insertion cells; the item flagged
// last closes the list and one result gives twice the median.
// ----------------------------------------------------------------------------
// Throughput: one element per cycle while loading; the insertion chain takes
//   a new item every cycle.
// Closing a list: the chain shifts its kept elements toward its head until
//   the lower middle one sits in the head cell, then the sum is formed and
//   the result register strobes. busy is high while shifting and summing.
// Reset empties the chain (valid bits only), zeroes the count and drop flag.
// The receiver cannot stall: each result is shown for one cycle.
module list_median_core #(
   parameter int MAX_ELEMENTS = 128,
   parameter int VALUE_BITS   = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [lm_pkg::REQ_BITS-1:0]           req_value,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   output logic signed [lm_pkg::MEDIAN_BITS-1:0] rsp_median_doubled,
   output logic [lm_pkg::COUNT_BITS-1:0]         rsp_count,
   output logic                                  rsp_overflow
);
   import lm_pkg::*;

   localparam int CW = $clog2(MAX_ELEMENTS + 1);

   localparam logic [1:0] S_LOAD = 2'd0;
   localparam logic [1:0] S_SEEK = 2'd1;
   localparam logic [1:0] S_SUM  = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic          odd_ff, odd_in;
   logic [CW-1:0] fin_count_ff, fin_count_in;
   logic          fin_drop_ff, fin_drop_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [MEDIAN_BITS-1:0] rsp_median_ff, rsp_median_in;
   logic [COUNT_BITS-1:0]         rsp_count_ff, rsp_count_in;
   logic                          rsp_overflow_ff, rsp_overflow_in;

   cell_ctrl_type                ctrl;
   logic signed [VALUE_BITS-1:0] new_value;
   logic                         accept;
   logic                         fits;
   logic [CW-1:0]                n_close;
   logic signed [VALUE_BITS:0]   mid_sum;

   logic                         cell_valid [MAX_ELEMENTS];
   logic signed [VALUE_BITS-1:0] cell_value [MAX_ELEMENTS];

   assign accept    = start && (state_ff == S_LOAD);
   assign fits      = count_ff < CW'(MAX_ELEMENTS);
   assign n_close   = count_ff + CW'(fits);
   assign new_value = req_value[VALUE_BITS-1:0];

   // Odd count: twice the middle element; even: sum of the two middle ones
   assign mid_sum = (VALUE_BITS + 1)'(cell_value[0])
                  + (VALUE_BITS + 1)'(odd_ff ? cell_value[0] : cell_value[1]);

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      dropped_in      = dropped_ff;
      steps_in        = steps_ff;
      odd_in          = odd_ff;
      fin_count_in    = fin_count_ff;
      fin_drop_in     = fin_drop_ff;
      rsp_valid_in    = 1'b0;
      rsp_median_in   = rsp_median_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_overflow_in = rsp_overflow_ff;
      ctrl            = '0;
      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               ctrl.insert = fits;
               count_in    = n_close;
               dropped_in  = dropped_ff || !fits;
               if (req_last) begin
                  fin_count_in = n_close;
                  fin_drop_in  = dropped_ff || !fits;
                  odd_in       = n_close[0];
                  // head lands on the lower middle element after this many shifts
                  steps_in     = n_close[0] ? (n_close >> 1) : ((n_close >> 1) - CW'(1));
                  state_in     = S_SEEK;
               end
            end
         end
         S_SEEK: begin
            if (steps_ff == '0) begin
               state_in = S_SUM;
            end else begin
               ctrl.shift = 1'b1;
               steps_in   = steps_ff - CW'(1);
            end
         end
         S_SUM: begin
            rsp_valid_in    = 1'b1;
            rsp_median_in   = MEDIAN_BITS'(mid_sum);
            rsp_count_in    = COUNT_BITS'(fin_count_ff);
            rsp_overflow_in = fin_drop_ff;
            ctrl.clear      = 1'b1;
            count_in        = '0;
            dropped_in      = 1'b0;
            state_in        = S_LOAD;
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      odd_ff          <= odd_in;
      fin_count_ff    <= fin_count_in;
      fin_drop_ff     <= fin_drop_in;
      rsp_median_ff   <= rsp_median_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      logic                         left_valid;
      logic signed [VALUE_BITS-1:0] left_value;
      logic                         right_valid;
      logic signed [VALUE_BITS-1:0] right_value;

      if (i == 0) begin : g_head
         assign left_valid = 1'b0;
         assign left_value = '0;
      end else begin : g_body
         assign left_valid = cell_valid[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == MAX_ELEMENTS - 1) begin : g_tail
         assign right_valid = 1'b0;
         assign right_value = '0;
      end else begin : g_inner
         assign right_valid = cell_valid[i+1];
         assign right_value = cell_value[i+1];
      end

      lm_cell #(
         .VALUE_BITS (VALUE_BITS),
         .FIRST      (i == 0)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_value   (new_value),
         .left_valid  (left_valid),
         .left_value  (left_value),
         .right_valid (right_valid),
         .right_value (right_value),
         .cell_valid  (cell_valid[i]),
         .cell_value  (cell_value[i])
      );
   end

   assign busy               = (state_ff != S_LOAD);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = rsp_median_ff;
   assign rsp_count          = rsp_count_ff;
   assign rsp_overflow       = rsp_overflow_ff;

   a_strobe_after_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == S_SUM)
      else $error("result strobe without a closing sum");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ELEMENTS))
      else $error("element count beyond capacity");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy && count_ff == '0)
      else $error("result shown while chain not emptied");

   a_seek_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEEK && steps_ff != '0 |=> steps_ff == $past(steps_ff) - CW'(1))
      else $error("shift counter skipped");

endmodule
